// ----- src/bdfd_pkg.sv -----
// Package: shared types and constants for the Bahai date converter.
`default_nettype none

package bdfd_pkg;

    localparam int DayWidth   = 23;
    localparam int YearWidth  = 16;
    localparam int MonthWidth = 5;

    // day_number + U_OFFSET = (day - first day of year 475) + 3*CYCLE_DAYS, never negative
    localparam int U_OFFSET       = 968503;
    localparam int CYCLE_DAYS     = 1029983;
    localparam int CYCLE_YEARS    = 2820;
    localparam int CYCLE_LAST_DAY = 1029982;
    localparam int MAX_CYCLES     = 9;
    localparam int RECIP_366      = 1466861;
    localparam int YEAR_NUM_DIV   = 1028522;
    localparam int YEAR_NUM_BIAS  = 2815;
    localparam int YEAR_NUM_SCALE = 2816;
    localparam int MAX_YEAR_STEP  = 6;
    // year = yc + 2820*q - 7986, Badi = year - 1222
    localparam int YEAR_ZERO      = 7986;
    localparam int BADI_SHIFT     = 9208;
    localparam int EPOCH_YEAR     = 474;
    localparam int LEAP_MUL       = 682;
    localparam int LEAP_SUB       = 110;
    localparam int RECIP_11       = 11916;
    localparam int START_YEAR_ONE = 173125;
    localparam int L_OF_474       = 114;
    localparam int RECIP_19       = 432;
    localparam int REGULAR_DAYS   = 342;

    typedef struct packed {
        logic [3:0]  cyc;
        logic [11:0] yc;
        logic [19:0] cday;
    } bdfd_year_t;

    typedef struct packed {
        logic [YearWidth-1:0]  badi_year;
        logic [MonthWidth-1:0] bahai_month;
        logic [MonthWidth-1:0] bahai_day;
        logic                  is_intercalary;
    } bdfd_date_t;

endpackage

`default_nettype wire

// ----- src/bdfd_year.sv -----
// Front pipeline: day number to 2820-year cycle, day in cycle and year in cycle.
`default_nettype none

module bdfd_year (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [bdfd_pkg::DayWidth-1:0]   day_number,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output bdfd_pkg::bdfd_year_t                 out_data
);
    import bdfd_pkg::*;

    localparam int Stages = 5;

    logic [Stages-1:0] v_reg, v_next, adv;

    logic [23:0] a_u_reg, a_u_next;
    logic [23:0] b_base;
    logic [3:0]  b_q_reg, b_q_next;
    logic [19:0] b_cday_reg, b_cday_next;
    logic [40:0] c_prod;
    logic [3:0]  c_q_reg;
    logic [19:0] c_cday_reg;
    logic [11:0] c_a1_reg, c_a1_next;
    logic [31:0] d_num32;
    logic [22:0] d_num_reg, d_num_next;
    logic [11:0] d_a1_reg;
    logic [3:0]  d_q_reg;
    logic [19:0] d_cday_reg;
    logic        d_last_reg, d_last_next;
    logic [2:0]  e_t;
    bdfd_year_t  e_reg, e_next;

    always_comb
    begin
        adv[Stages-1] = !v_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next = v_reg;
        if (adv[0])
        begin
            v_next[0] = in_valid;
        end
        for (int i = 1; i < Stages; i++)
        begin
            if (adv[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage A: shift to a non-negative offset
    assign a_u_next = 24'(day_number) + 24'(U_OFFSET);

    // stage B: cycle number by constant compares
    always_comb
    begin
        b_q_next = '0;
        b_base   = '0;
        for (int k = 1; k <= MAX_CYCLES; k++)
        begin
            if (a_u_reg >= 24'(k * CYCLE_DAYS))
            begin
                b_q_next = 4'(k);
                b_base   = 24'(k * CYCLE_DAYS);
            end
        end
        b_cday_next = 20'(a_u_reg - b_base);
    end

    // stage C: cday / 366 by reciprocal
    assign c_prod    = 41'(b_cday_reg) * 41'(RECIP_366);
    assign c_a1_next = c_prod[40:29];

    // stage D: 2134*a1 + 2816*(cday mod 366) + 2815, folded
    assign d_num32 = 32'(c_cday_reg) * 32'(YEAR_NUM_SCALE) + 32'(YEAR_NUM_BIAS)
                   - 32'(c_a1_reg) * 32'(YEAR_NUM_DIV);
    assign d_num_next  = d_num32[22:0];
    assign d_last_next = (c_cday_reg == 20'(CYCLE_LAST_DAY));

    // stage E: year within cycle
    always_comb
    begin
        e_t = '0;
        for (int k = 1; k <= MAX_YEAR_STEP; k++)
        begin
            if (d_num_reg >= 23'(k * YEAR_NUM_DIV))
            begin
                e_t = 3'(k);
            end
        end
        e_next.cyc  = d_q_reg;
        e_next.cday = d_cday_reg;
        e_next.yc   = d_last_reg ? 12'(CYCLE_YEARS) : d_a1_reg + 12'(e_t) + 12'd1;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_u_reg <= a_u_next;
        end
        if (adv[1])
        begin
            b_q_reg    <= b_q_next;
            b_cday_reg <= b_cday_next;
        end
        if (adv[2])
        begin
            c_q_reg    <= b_q_reg;
            c_cday_reg <= b_cday_reg;
            c_a1_reg   <= c_a1_next;
        end
        if (adv[3])
        begin
            d_num_reg  <= d_num_next;
            d_a1_reg   <= c_a1_reg;
            d_q_reg    <= c_q_reg;
            d_cday_reg <= c_cday_reg;
            d_last_reg <= d_last_next;
        end
        if (adv[4])
        begin
            e_reg <= e_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[Stages-1];
    assign out_data  = e_reg;

endmodule

`default_nettype wire

// ----- src/bdfd_date.sv -----
// Back pipeline: year, day in year, leap test and month/day split.
`default_nettype none

module bdfd_date (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  bdfd_pkg::bdfd_year_t       in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output bdfd_pkg::bdfd_date_t       out_data
);
    import bdfd_pkg::*;

    localparam int Stages = 5;

    logic [Stages-1:0] v_reg, v_next, adv;

    logic [16:0] f_sum, f_badi;
    logic        f_neg;
    logic [12:0] f_e0, f_e1;
    logic [21:0] f_p0, f_p1;
    logic [15:0] f_badi_reg;
    logic [13:0] f_h0_reg, f_h1_reg;
    logic        f_wrap_reg;
    logic [11:0] f_yc_reg;
    logic [19:0] f_cday_reg;

    logic [27:0] g_p0, g_p1;
    logic [15:0] g_badi_reg;
    logic [9:0]  g_l0_reg, g_l1_reg;
    logic        g_wrap_reg;
    logic [11:0] g_yc_reg;
    logic [19:0] g_cday_reg;

    logic [9:0]  h_lc;
    logic [21:0] h_idx22;
    logic [15:0] h_badi_reg;
    logic [8:0]  h_idx_reg;
    logic        h_leap_reg;

    logic [17:0] i_prod;
    logic [15:0] i_badi_reg;
    logic [8:0]  i_idx_reg;
    logic [4:0]  i_mq_reg;
    logic        i_leap_reg;

    logic [8:0]  j_day9;
    bdfd_date_t  j_reg, j_next;

    always_comb
    begin
        adv[Stages-1] = !v_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next = v_reg;
        if (adv[0])
        begin
            v_next[0] = in_valid;
        end
        for (int i = 1; i < Stages; i++)
        begin
            if (adv[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage F: year (no year zero) and leap numerators
    always_comb
    begin
        f_sum  = 17'(in_data.yc) + 17'(in_data.cyc) * 17'(CYCLE_YEARS);
        f_neg  = (f_sum <= 17'(YEAR_ZERO));
        f_badi = f_sum - 17'(BADI_SHIFT) - 17'(f_neg);
        f_e0   = 13'(in_data.yc) + 13'(EPOCH_YEAR);
        f_e1   = (in_data.yc == 12'(CYCLE_YEARS)) ? 13'(EPOCH_YEAR + 1) : f_e0 + 13'd1;
        f_p0   = 22'(f_e0) * 22'(LEAP_MUL) - 22'(LEAP_SUB);
        f_p1   = 22'(f_e1) * 22'(LEAP_MUL) - 22'(LEAP_SUB);
    end

    // stage G: divide by 11 by reciprocal
    assign g_p0 = 28'(f_h0_reg) * 28'(RECIP_11);
    assign g_p1 = 28'(f_h1_reg) * 28'(RECIP_11);

    // stage H: day index and leap bit
    always_comb
    begin
        h_lc    = g_wrap_reg ? 10'(L_OF_474) : g_l0_reg;
        h_idx22 = 22'(g_cday_reg) + 22'(START_YEAR_ONE) - 22'(g_l0_reg)
                - (22'(g_yc_reg) + 22'(EPOCH_YEAR - 1)) * 22'd365;
    end

    // stage I: idx / 19 by reciprocal
    assign i_prod = 18'(h_idx_reg) * 18'(RECIP_19);

    // stage J: month and day
    always_comb
    begin
        j_next.badi_year      = i_badi_reg;
        j_next.is_intercalary = 1'b0;
        if (i_idx_reg < 9'(REGULAR_DAYS))
        begin
            j_next.bahai_month = i_mq_reg + 5'd1;
            j_day9 = i_idx_reg - 9'(i_mq_reg) * 9'd19 + 9'd1;
        end
        else if (i_idx_reg < 9'(REGULAR_DAYS + 4) + 9'(i_leap_reg))
        begin
            j_next.bahai_month    = 5'd0;
            j_next.is_intercalary = 1'b1;
            j_day9 = i_idx_reg - 9'(REGULAR_DAYS - 1);
        end
        else
        begin
            j_next.bahai_month = 5'd19;
            j_day9 = i_idx_reg - 9'(REGULAR_DAYS + 3) - 9'(i_leap_reg);
        end
        j_next.bahai_day = j_day9[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            f_badi_reg <= f_badi[15:0];
            f_h0_reg   <= f_p0[21:8];
            f_h1_reg   <= f_p1[21:8];
            f_wrap_reg <= (in_data.yc == 12'(CYCLE_YEARS));
            f_yc_reg   <= in_data.yc;
            f_cday_reg <= in_data.cday;
        end
        if (adv[1])
        begin
            g_badi_reg <= f_badi_reg;
            g_l0_reg   <= g_p0[26:17];
            g_l1_reg   <= g_p1[26:17];
            g_wrap_reg <= f_wrap_reg;
            g_yc_reg   <= f_yc_reg;
            g_cday_reg <= f_cday_reg;
        end
        if (adv[2])
        begin
            h_badi_reg <= g_badi_reg;
            h_idx_reg  <= h_idx22[8:0];
            h_leap_reg <= (g_l1_reg != h_lc);
        end
        if (adv[3])
        begin
            i_badi_reg <= h_badi_reg;
            i_idx_reg  <= h_idx_reg;
            i_mq_reg   <= i_prod[17:13];
            i_leap_reg <= h_leap_reg;
        end
        if (adv[4])
        begin
            j_reg <= j_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[Stages-1];
    assign out_data  = j_reg;

endmodule

`default_nettype wire

// ----- src/bahai_date_from_day_number.sv -----
// Top level: Julian day number to Bahai (Badi) date, ten-stage pipeline.
//
//  channel  | dir | tdata [lsb up]                       | tuser
//  s_axis   | in  | day_number[22:0], pad                | -
//  m_axis   | out | badi_year[15:0], month[20:16],        | is_intercalary
//           |     | day[25:21], pad                      |
//
// One item per cycle sustained while m_tready is high, through the ten register
// stages (cycle/year split front, date split back).
// Reset clears only the stage valid bits.
// Each stage holds under a stall and refills bubbles; s_tready follows the
// ready chain from m_tready.
`default_nettype none

module bahai_date_from_day_number (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // day_number[22:0], pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // badi_year, bahai_month, bahai_day, pad
    output logic             m_tuser    // is_intercalary
);
    import bdfd_pkg::*;

    logic       mid_valid, mid_ready;
    bdfd_year_t mid_data;
    bdfd_date_t res;

    bdfd_year u_year (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .day_number (s_tdata[DayWidth-1:0]),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_data   (mid_data)
    );

    bdfd_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {6'd0, res.bahai_day, res.bahai_month, res.badi_year};
    assign m_tuser = res.is_intercalary;

endmodule

`default_nettype wire

// ----- src/bdfd_check.sv -----
// Checker: output channel properties, bound to the top level.
`default_nettype none

module bdfd_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_icday: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[20:16] == 5'd0 && m_tdata[25:21] != 5'd0
                                && m_tdata[25:21] <= 5'd5)
        else $error("bad intercalary date");

    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[20:16] != 5'd0 && m_tdata[20:16] <= 5'd19)
        else $error("bad month");

    a_day: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:21] != 5'd0 && m_tdata[25:21] <= 5'd19
                     && m_tdata[31:26] == 6'd0)
        else $error("bad day or pad");

endmodule

bind bahai_date_from_day_number bdfd_check u_bdfd_check (.*);

`default_nettype wire
